// ===== rtl/core/bc1_pkg.sv =====
// ----------------------------------------------------------------------------
// bc1_pkg
// Shared types, constants and helpers for the BC1 block decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bc1_pkg;

    // Block geometry
    localparam int unsigned PixPerBlock = 16;
    localparam int unsigned PosW        = $clog2(PixPerBlock);
    localparam int unsigned ColorW      = 16;
    localparam int unsigned IndexW      = 2 * PixPerBlock;
    localparam int unsigned PalSize     = 4;
    localparam int unsigned SelW        = $clog2(PalSize);

    // RGB565 channel fields
    localparam logic [ColorW-1:0] RedMask   = 16'hF800;
    localparam logic [ColorW-1:0] GreenMask = 16'h07E0;
    localparam logic [ColorW-1:0] BlueMask  = 16'h001F;

    // Reciprocal of three for values below 512: floor(x / 3) = (x * 171) >> 9
    localparam logic [7:0] Recip3 = 8'd171;

    // Per-channel weighted sums, wide enough for 2*63 + 63
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } bc1_sum_t;

    // Finished palette plus the block's indices
    typedef struct packed {
        logic [PalSize-1:0][ColorW-1:0] color;
        logic [IndexW-1:0]              index_bits;
    } bc1_block_t;

    // Divide an 8-bit sum by three, truncating
    function automatic logic [6:0] div3(input logic [7:0] x);
        logic [15:0] prod;
        begin
            prod = 16'(x) * 16'(Recip3);
            return prod[15:9];
        end
    endfunction

    // Split an RGB565 word into zero-extended channels
    function automatic bc1_sum_t split565(input logic [ColorW-1:0] c);
        bc1_sum_t s;
        begin
            s.r = 8'((c & RedMask) >> 11);
            s.g = 8'((c & GreenMask) >> 5);
            s.b = 8'(c & BlueMask);
            return s;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bc1_blk_if.sv =====
// ----------------------------------------------------------------------------
// bc1_blk_if
// Compressed block channel: two RGB565 endpoints and sixteen 2-bit indices.
// ----------------------------------------------------------------------------
`default_nettype none

interface bc1_blk_if;
    logic        valid;
    logic        ready;
    logic [15:0] endpoint_a;
    logic [15:0] endpoint_b;
    logic [31:0] index_bits;

    modport source (output valid, output endpoint_a, output endpoint_b,
                    output index_bits, input ready);
    modport sink   (input valid, input endpoint_a, input endpoint_b,
                    input index_bits, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bc1_pix_if.sv =====
// ----------------------------------------------------------------------------
// bc1_pix_if
// Decoded pixel channel: one RGB565 color per word with its block position.
// ----------------------------------------------------------------------------
`default_nettype none

interface bc1_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_color;
    logic [3:0]  pixel_position;
    logic        last_pixel;

    modport source (output valid, output pixel_color, output pixel_position,
                    output last_pixel, input ready);
    modport sink   (input valid, input pixel_color, input pixel_position,
                    input last_pixel, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bc1_palette.sv =====
// ----------------------------------------------------------------------------
// bc1_palette
// Two-stage palette builder: weighted channel sums, then divide and assemble.
// ----------------------------------------------------------------------------
`default_nettype none

module bc1_palette (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [15:0]         endpoint_a,
    input  wire logic [15:0]         endpoint_b,
    input  wire logic [31:0]         index_bits,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output bc1_pkg::bc1_block_t      out_block
);
    import bc1_pkg::*;

    // Stage 1 registers
    logic                  s1_valid_reg;
    logic [ColorW-1:0]     s1_a_reg;
    logic [ColorW-1:0]     s1_b_reg;
    logic [IndexW-1:0]     s1_idx_reg;
    logic                  s1_gt_reg;
    bc1_sum_t              s1_hi_reg;
    bc1_sum_t              s1_lo_reg;
    bc1_sum_t              s1_mid_reg;

    // Stage 2 registers
    logic                  s2_valid_reg;
    bc1_block_t            s2_block_reg;

    logic                  s1_ready;
    logic                  s2_ready;
    bc1_sum_t              ch_a;
    bc1_sum_t              ch_b;
    bc1_sum_t              hi_next;
    bc1_sum_t              lo_next;
    bc1_sum_t              mid_next;
    logic [ColorW-1:0]     c2_next;
    logic [ColorW-1:0]     c3_next;
    bc1_block_t            s2_block_next;

    // Stall chain: a stage advances when the next one has room
    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Form 2A+B, A+2B and A+B per channel
    always_comb
    begin
        ch_a       = split565(endpoint_a);
        ch_b       = split565(endpoint_b);
        hi_next.r  = (ch_a.r << 1) + ch_b.r;
        hi_next.g  = (ch_a.g << 1) + ch_b.g;
        hi_next.b  = (ch_a.b << 1) + ch_b.b;
        lo_next.r  = ch_a.r + (ch_b.r << 1);
        lo_next.g  = ch_a.g + (ch_b.g << 1);
        lo_next.b  = ch_a.b + (ch_b.b << 1);
        mid_next.r = ch_a.r + ch_b.r;
        mid_next.g = ch_a.g + ch_b.g;
        mid_next.b = ch_a.b + ch_b.b;
    end

    // Divide the sums and assemble the four palette colors
    always_comb
    begin
        if (s1_gt_reg)
        begin
            c2_next = {5'(div3(s1_hi_reg.r)), 6'(div3(s1_hi_reg.g)),
                       5'(div3(s1_hi_reg.b))};
            c3_next = {5'(div3(s1_lo_reg.r)), 6'(div3(s1_lo_reg.g)),
                       5'(div3(s1_lo_reg.b))};
        end
        else
        begin
            c2_next = {s1_mid_reg.r[5:1], s1_mid_reg.g[6:1], s1_mid_reg.b[5:1]};
            c3_next = '0;
        end
        s2_block_next.color[0]   = s1_a_reg;
        s2_block_next.color[1]   = s1_b_reg;
        s2_block_next.color[2]   = c2_next;
        s2_block_next.color[3]   = c3_next;
        s2_block_next.index_bits = s1_idx_reg;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload: load on advance, hold on stall
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_a_reg   <= endpoint_a;
            s1_b_reg   <= endpoint_b;
            s1_idx_reg <= index_bits;
            s1_gt_reg  <= endpoint_a > endpoint_b;
            s1_hi_reg  <= hi_next;
            s1_lo_reg  <= lo_next;
            s1_mid_reg <= mid_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_block_reg <= s2_block_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_block = s2_block_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bc1_block_decoder.sv =====
// ----------------------------------------------------------------------------
// bc1_block_decoder
// BC1 (DXT1) block decoder: one compressed block in, sixteen pixels out.
// ----------------------------------------------------------------------------
// Usage:
//   blk  (sink)   one word per 64-bit block: endpoint_a, endpoint_b and the
//                 sixteen 2-bit indices, pixel i in index_bits[2i+1:2i].
//   pix  (source) one word per pixel in raster order within the block, with
//                 its position 0..15; last_pixel marks position 15.
//   A block passes through the sum stage, the divide stage and the pixel
//   output register before its first pixel shows.
//   Throughput: one pixel per cycle while pix.ready is high; the pixel
//   serializer is the limit. The two palette stages hold two further blocks
//   while the current block is still being emitted; then blk.ready drops.
//   Reset clears every valid bit; no word is pending afterwards.
//   When pix.ready is low the current pixel holds, the serializer stops, and
//   the palette stages fill and then drop blk.ready; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module bc1_block_decoder (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bc1_blk_if.sink    blk,
    bc1_pix_if.source  pix
);
    import bc1_pkg::*;

    logic                  pal_valid;
    logic                  pal_ready;
    bc1_block_t            pal_block;

    // Serializer / output register
    logic                  out_valid_reg;
    logic [ColorW-1:0]     color_reg;
    logic [PosW-1:0]       count_reg;
    logic                  last_reg;
    logic [PalSize-1:0][ColorW-1:0] pal_reg;
    logic [IndexW-1:0]     idx_reg;

    logic                  load;
    logic                  advance;
    logic                  drain;

    bc1_palette u_palette (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (blk.valid),
        .in_ready   (blk.ready),
        .endpoint_a (blk.endpoint_a),
        .endpoint_b (blk.endpoint_b),
        .index_bits (blk.index_bits),
        .out_valid  (pal_valid),
        .out_ready  (pal_ready),
        .out_block  (pal_block)
    );

    // Take a new block when empty or when the last pixel leaves
    assign pal_ready = !out_valid_reg || (pix.ready && last_reg);
    assign load      = pal_valid && pal_ready;
    assign advance   = out_valid_reg && pix.ready && !last_reg;
    assign drain     = out_valid_reg && pix.ready && last_reg && !pal_valid;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            last_reg      <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
            count_reg     <= '0;
            last_reg      <= 1'b0;
        end
        else if (advance)
        begin
            count_reg <= count_reg + PosW'(1);
            last_reg  <= (count_reg == PosW'(PixPerBlock - 2));
        end
        else if (drain)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Palette, remaining indices and current color
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pal_reg   <= pal_block.color;
            idx_reg   <= pal_block.index_bits >> SelW;
            color_reg <= pal_block.color[pal_block.index_bits[SelW-1:0]];
        end
        else if (advance)
        begin
            idx_reg   <= idx_reg >> SelW;
            color_reg <= pal_reg[idx_reg[SelW-1:0]];
        end
    end

    assign pix.valid          = out_valid_reg;
    assign pix.pixel_color    = color_reg;
    assign pix.pixel_position = count_reg;
    assign pix.last_pixel     = last_reg;

endmodule

`default_nettype wire

// ===== verif/bc1_block_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bc1_block_checker
// Watches the block and pixel channels of the BC1 decoder. For every block
// word it decodes the sixteen expected pixels. It compares each pixel word
// field by field, in order, against those pixels.
// ----------------------------------------------------------------------------

module bc1_block_checker (
    input  logic clk,
    input  logic rst_n,
    bc1_blk_if   blk,
    bc1_pix_if   pix,
    output int   error_count,
    output int   pending_count
);

    typedef struct packed {
        logic [bc1_pkg::ColorW-1:0] color;
        logic [bc1_pkg::PosW-1:0]   position;
        logic                       last;
    } pixel_word_t;

    pixel_word_t expected_pixels[$];

    // Blend two RGB565 colors per channel with integer weights, truncating
    function automatic logic [15:0] blend565(input logic [15:0] p, input logic [15:0] q,
                                             input int wp, input int wq, input int dv);
        int r;
        int g;
        int b;
        begin
            r = (wp * int'(p[15:11]) + wq * int'(q[15:11])) / dv;
            g = (wp * int'(p[10:5])  + wq * int'(q[10:5]))  / dv;
            b = (wp * int'(p[4:0])   + wq * int'(q[4:0]))   / dv;
            return {r[4:0], g[5:0], b[4:0]};
        end
    endfunction

    // Build the block's palette and queue its sixteen pixels in raster order
    task automatic decode_block(input logic [15:0] a, input logic [15:0] b,
                                input logic [31:0] idx);
        logic [15:0] palette[4];
        pixel_word_t px;
        begin
            palette[0] = a;
            palette[1] = b;
            if (a > b)
            begin
                palette[2] = blend565(a, b, 2, 1, 3);
                palette[3] = blend565(a, b, 1, 2, 3);
            end
            else
            begin
                palette[2] = blend565(a, b, 1, 1, 2);
                palette[3] = 16'h0000;
            end
            for (int k = 0; k < bc1_pkg::PixPerBlock; k++)
            begin
                px.color    = palette[idx[2*k +: 2]];
                px.position = 4'(k);
                px.last     = (k == bc1_pkg::PixPerBlock - 1);
                expected_pixels.push_back(px);
            end
        end
    endtask

    initial
    begin
        error_count   = 0;
        pending_count = 0;
    end

    // Sample both channels at the edge: predict first, then compare
    always @(posedge clk)
    begin : watch
        pixel_word_t want;
        if (rst_n)
        begin
            if (blk.valid && blk.ready)
                decode_block(blk.endpoint_a, blk.endpoint_b, blk.index_bits);
            if (pix.valid && pix.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: pixel word with none pending: color %h pos %0d last %b",
                             $time, pix.pixel_color, pix.pixel_position, pix.last_pixel);
                    error_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pix.pixel_color !== want.color)
                    begin
                        $display("%0t: pixel_color expected %h actual %h",
                                 $time, want.color, pix.pixel_color);
                        error_count++;
                    end
                    if (pix.pixel_position !== want.position)
                    begin
                        $display("%0t: pixel_position expected %0d actual %0d",
                                 $time, want.position, pix.pixel_position);
                        error_count++;
                    end
                    if (pix.last_pixel !== want.last)
                    begin
                        $display("%0t: last_pixel expected %b actual %b",
                                 $time, want.last, pix.last_pixel);
                        error_count++;
                    end
                end
            end
            pending_count = expected_pixels.size();
        end
    end

endmodule

// ===== verif/tb_bc1_block_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bc1_block_decoder
// Drives BC1 blocks into the decoder: a directed set covering endpoint order,
// equal endpoints, channel extremes and every palette index, then random
// blocks. Both channels pause at random. A separate checker predicts and
// compares every pixel word; this module only paces traffic and reports.
// ----------------------------------------------------------------------------

module tb_bc1_block_decoder;

    localparam int RandomBlocks = 260;
    localparam int IdleLimit    = 2000;
    localparam int DrainCycles  = 24;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   idle_cycles;
    bit   steady_source;
    int   stall_left;
    int   calm_left;

    bc1_blk_if blk_ch();
    bc1_pix_if pix_ch();

    bc1_block_decoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .blk   (blk_ch.sink),
        .pix   (pix_ch.source)
    );

    bc1_block_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .blk           (blk_ch),
        .pix           (pix_ch),
        .error_count   (errors),
        .pending_count (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Pick a source gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        begin
            roll = $urandom_range(0, 99);
            if (steady_source || roll < 60)
                return 0;
            else if (roll < 92)
                return $urandom_range(1, 3);
            else
                return $urandom_range(10, 40);
        end
    endfunction

    // Offer one block word and hold it until accepted
    task automatic send_block(input logic [15:0] a, input logic [15:0] b,
                              input logic [31:0] idx);
        int gap;
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                blk_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            blk_ch.valid      <= 1'b1;
            blk_ch.endpoint_a <= a;
            blk_ch.endpoint_b <= b;
            blk_ch.index_bits <= idx;
            @(posedge clk);
            while (!blk_ch.ready)
                @(posedge clk);
        end
    endtask

    // Random 565 color with each channel at its minimum or maximum
    function automatic logic [15:0] extreme_color();
        begin
            return {{5{1'($urandom)}}, {6{1'($urandom)}}, {5{1'($urandom)}}};
        end
    endfunction

    // Pace pix.ready: short and long stalls, with stall-free stretches
    always @(posedge clk)
    begin : sink_pacing
        int  roll;
        logic ready_next;
        ready_next = 1'b1;
        if (!rst_n)
            ready_next = 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            ready_next = 1'b0;
        end
        else if (calm_left > 0)
            calm_left--;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
                calm_left = $urandom_range(50, 250);
            else if (roll < 22)
            begin
                stall_left = $urandom_range(0, 2);
                ready_next = 1'b0;
            end
            else if (roll < 25)
            begin
                stall_left = $urandom_range(10, 40);
                ready_next = 1'b0;
            end
        end
        pix_ch.ready <= ready_next;
    end

    // End the run if no word moves on either channel for too long
    always @(posedge clk)
    begin
        if ((blk_ch.valid && blk_ch.ready) || (pix_ch.valid && pix_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IdleLimit)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] t;
        int          mode;

        rst_n             = 1'b0;
        idle_cycles       = 0;
        stall_left        = 0;
        calm_left         = 0;
        steady_source     = 1'b0;
        blk_ch.valid      = 1'b0;
        blk_ch.endpoint_a = '0;
        blk_ch.endpoint_b = '0;
        blk_ch.index_bits = '0;
        pix_ch.ready      = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: endpoint order, equal endpoints, channel extremes, all indices
        send_block(16'h0000, 16'h0000, 32'hE4E4_E4E4);
        send_block(16'hFFFF, 16'hFFFF, 32'hE4E4_E4E4);
        send_block(16'hFFFF, 16'h0000, 32'hE4E4_E4E4);
        send_block(16'h0000, 16'hFFFF, 32'hE4E4_E4E4);
        send_block(16'h1234, 16'h1234, 32'hFFFF_FFFF);
        send_block(16'h8001, 16'h8000, 32'hAAAA_AAAA);
        send_block(16'h8000, 16'h8001, 32'hAAAA_AAAA);
        send_block(16'hF800, 16'h07E0, 32'h1B1B_1B1B);
        send_block(16'h07E0, 16'hF800, 32'h1B1B_1B1B);
        send_block(16'h001F, 16'hF800, 32'h4E4E_4E4E);
        send_block(16'hF800, 16'h001F, 32'h4E4E_4E4E);
        send_block(16'hFFE0, 16'h001F, 32'h0000_0000);
        send_block(16'h7BEF, 16'h8410, 32'h5555_5555);
        send_block(16'h8410, 16'h7BEF, 32'hFFFF_FFFF);
        send_block(16'hFFFF, 16'hFFFE, 32'hFFFF_FFFF);
        send_block(16'h0001, 16'h0000, 32'hAAAA_AAAA);
        send_block(16'hFFDF, 16'h0020, 32'h39C6_39C6);
        send_block(16'hA5A5, 16'h5A5A, 32'h0123_4567);
        send_block(16'h5A5A, 16'hA5A5, 32'h89AB_CDEF);
        send_block(16'h07FF, 16'h07FF, 32'hFEDC_BA98);

        // Random blocks: mix of four-color, three-color, equal and extreme endpoints
        for (int n = 0; n < RandomBlocks; n++)
        begin
            if (n % 40 == 0)
                steady_source = ($urandom_range(0, 3) == 0);
            a    = 16'($urandom);
            b    = 16'($urandom);
            mode = $urandom_range(0, 9);
            if (mode < 2 && a < b)
            begin
                t = a;
                a = b;
                b = t;
            end
            else if (mode < 4 && a > b)
            begin
                t = a;
                a = b;
                b = t;
            end
            else if (mode == 4)
                b = a;
            else if (mode == 5)
            begin
                a = extreme_color();
                b = extreme_color();
            end
            send_block(a, b, $urandom);
        end
        blk_ch.valid <= 1'b0;

        // Let the checker see the last block, drain outstanding pixels, then watch
        // for strays
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
